// File: hdl/evcps_pkg.sv
// Shared types, state codes and register indexes for the charge pilot sequencer.
package evcps_pkg;

  localparam int unsigned TimerW    = 16;
  localparam int unsigned TickW     = 10;
  localparam int unsigned StateW    = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Sequencer state codes
  localparam logic [StateW-1:0] StOff       = 3'd0;
  localparam logic [StateW-1:0] StWaitPlug  = 3'd1;
  localparam logic [StateW-1:0] StPlugged   = 3'd2;
  localparam logic [StateW-1:0] StWaitBms   = 3'd3;
  localparam logic [StateW-1:0] StPrecharge = 3'd4;
  localparam logic [StateW-1:0] StCharging  = 3'd5;
  localparam logic [StateW-1:0] StStopping  = 3'd6;
  localparam logic [StateW-1:0] StFault     = 3'd7;

  // Pilot level codes
  localparam logic [2:0] LevelB = 3'd1;
  localparam logic [2:0] LevelC = 3'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegTickPeriod     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPlugConfirm    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReadyConfirm   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegInvalidTimeout = 2'd3;

  // Register reset values
  localparam logic [TickW-1:0]  TickPeriodRst     = 10'd10;
  localparam logic [TimerW-1:0] PlugConfirmRst    = 16'd100;
  localparam logic [TimerW-1:0] ReadyConfirmRst   = 16'd100;
  localparam logic [TimerW-1:0] InvalidTimeoutRst = 16'd1000;

  typedef struct packed {
    logic [2:0]         pilot_level;
    logic               pwm_ok;
    logic               digital_comm_needed;
    logic               pilot_ok;
    logic               fault_in;
    logic signed [15:0] requested_current;
  } in_req_t;

  typedef struct packed {
    logic              plug_det;
    logic              veh_rdy;
    logic              fault_out;
    logic              chg_armed;
    logic              chg_permit;
    logic              wakeup_request;
    logic              power_enable;
    logic [StateW-1:0] machine_state;
  } out_res_t;

  // Confirmed conditions handed to the sequencer
  typedef struct packed {
    logic plug;
    logic veh;
    logic fault;
    logic cur_pos;
  } seq_cond_t;

endpackage

// File: hdl/evcps_timer.sv
// Saturating millisecond confirm timer with threshold compare.
module evcps_timer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           run_i,
  input  logic [evcps_pkg::TickW-1:0]    tick_i,
  input  logic [evcps_pkg::TimerW-1:0]   limit_i,
  output logic                           reached_o
);

  logic [evcps_pkg::TimerW-1:0] time_q, time_d;
  logic [evcps_pkg::TimerW:0]   sum;

  assign sum = {1'b0, time_q} + {{(evcps_pkg::TimerW+1-evcps_pkg::TickW){1'b0}}, tick_i};

  always_comb begin
    if (!run_i) begin
      time_d = '0;
    end else if (sum[evcps_pkg::TimerW]) begin
      time_d = '1;
    end else begin
      time_d = sum[evcps_pkg::TimerW-1:0];
    end
  end

  // Flag is judged on the updated time
  assign reached_o = time_d >= limit_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (step_i) begin
      time_q <= time_d;
    end
  end

endmodule

// File: hdl/evcps_seq.sv
// Eight-state charging sequencer: state register and next-state logic.
module evcps_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  evcps_pkg::seq_cond_t           cond_i,
  output logic [evcps_pkg::StateW-1:0]   state_d_o
);

  logic [evcps_pkg::StateW-1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      evcps_pkg::StOff: begin
        state_d = evcps_pkg::StWaitPlug;
      end
      evcps_pkg::StWaitPlug: begin
        if (cond_i.plug) state_d = evcps_pkg::StPlugged;
      end
      evcps_pkg::StPlugged: begin
        if (!cond_i.plug)     state_d = evcps_pkg::StWaitPlug;
        else if (cond_i.veh)  state_d = evcps_pkg::StWaitBms;
      end
      evcps_pkg::StWaitBms: begin
        if (!cond_i.plug)         state_d = evcps_pkg::StWaitPlug;
        else if (cond_i.fault)    state_d = evcps_pkg::StFault;
        else if (cond_i.cur_pos)  state_d = evcps_pkg::StPrecharge;
      end
      evcps_pkg::StPrecharge: begin
        // holds here while a fault persists and plug and vehicle stay confirmed
        if (!cond_i.plug || !cond_i.veh) state_d = evcps_pkg::StStopping;
        else if (!cond_i.fault)          state_d = evcps_pkg::StCharging;
      end
      evcps_pkg::StCharging: begin
        if (!cond_i.plug || !cond_i.veh || cond_i.fault) state_d = evcps_pkg::StStopping;
      end
      evcps_pkg::StStopping: begin
        if (!cond_i.plug)     state_d = evcps_pkg::StWaitPlug;
        else if (!cond_i.veh) state_d = evcps_pkg::StPlugged;
      end
      default: begin
        if (!cond_i.fault && cond_i.plug) state_d = evcps_pkg::StPlugged;
      end
    endcase
  end

  assign state_d_o = state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evcps_pkg::StWaitPlug;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/ev_charge_pilot_sequencer_core.sv
// Top level of the charge pilot sequencer: request/result registers, config and datapath.
// One control tick per request; a new request is taken every clock cycle unless the output
// stalls; each result passes the input register and then the result register. The three
// confirm timers and the sequencer state advance only when a request moves from the input
// register into the result register, so output back-pressure simply holds the pipeline.
// Configuration writes take effect on the next clock edge and should be made while idle.
module ev_charge_pilot_sequencer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  evcps_pkg::in_req_t               in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output evcps_pkg::out_res_t              out_res_o,
  input  logic                             cfg_we_i,
  input  logic [evcps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [evcps_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  logic [evcps_pkg::TickW-1:0]  tick_q;
  logic [evcps_pkg::TimerW-1:0] plug_conf_q, ready_conf_q, inv_tmo_q;

  evcps_pkg::in_req_t  req_q;
  logic                req_valid_q;
  evcps_pkg::out_res_t res_q, res_d;
  logic                res_valid_q;
  logic                advance;

  logic                connected, ready, inv_reached;
  logic                plug_hit, veh_hit;
  evcps_pkg::seq_cond_t cond;
  logic [evcps_pkg::StateW-1:0] st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= evcps_pkg::TickPeriodRst;
      plug_conf_q  <= evcps_pkg::PlugConfirmRst;
      ready_conf_q <= evcps_pkg::ReadyConfirmRst;
      inv_tmo_q    <= evcps_pkg::InvalidTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        evcps_pkg::RegTickPeriod:     tick_q       <= cfg_wdata_i[evcps_pkg::TickW-1:0];
        evcps_pkg::RegPlugConfirm:    plug_conf_q  <= cfg_wdata_i;
        evcps_pkg::RegReadyConfirm:   ready_conf_q <= cfg_wdata_i;
        evcps_pkg::RegInvalidTimeout: inv_tmo_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Request moves into the result register when that register is free or draining
  assign advance    = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign connected = (req_q.pilot_level == evcps_pkg::LevelB) ||
                     (req_q.pilot_level == evcps_pkg::LevelC);
  assign ready     = (req_q.pilot_level == evcps_pkg::LevelC) && req_q.pwm_ok &&
                     !req_q.digital_comm_needed;

  evcps_timer u_plug_tmr (
    .clk_i, .rst_ni, .step_i(advance), .run_i(connected), .tick_i(tick_q),
    .limit_i(plug_conf_q), .reached_o(plug_hit)
  );

  evcps_timer u_ready_tmr (
    .clk_i, .rst_ni, .step_i(advance), .run_i(ready), .tick_i(tick_q),
    .limit_i(ready_conf_q), .reached_o(veh_hit)
  );

  evcps_timer u_inv_tmr (
    .clk_i, .rst_ni, .step_i(advance), .run_i(!req_q.pilot_ok), .tick_i(tick_q),
    .limit_i(inv_tmo_q), .reached_o(inv_reached)
  );

  assign cond = '{plug:    plug_hit,
                  veh:     veh_hit,
                  fault:   req_q.fault_in || inv_reached,
                  cur_pos: !req_q.requested_current[15] && (|req_q.requested_current)};

  evcps_seq u_seq (
    .clk_i, .rst_ni, .step_i(advance), .cond_i(cond), .state_d_o(st)
  );

  always_comb begin
    res_d.plug_det       = cond.plug;
    res_d.veh_rdy        = cond.veh;
    res_d.fault_out      = cond.fault;
    res_d.chg_armed      = (st == evcps_pkg::StWaitBms) || (st == evcps_pkg::StPrecharge) ||
                           (st == evcps_pkg::StCharging);
    res_d.chg_permit     = (st == evcps_pkg::StPrecharge) || (st == evcps_pkg::StCharging);
    res_d.wakeup_request = st != evcps_pkg::StWaitPlug;
    res_d.power_enable   = res_d.chg_permit && !cond.fault;
    res_d.machine_state  = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule

// File: hdl/evcps_checker.sv
// Port-level checks for the charge pilot sequencer, bound to the top level.
module evcps_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input evcps_pkg::out_res_t  out_res_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // Power only with charge allowed and no fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.power_enable |->
      out_res_o.chg_permit && !out_res_o.fault_out)
    else $error("power enabled without permission");

  // Allowed states are a subset of ready states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.chg_permit |-> out_res_o.chg_armed)
    else $error("charge allowed outside ready states");

  // Wakeup tracks the state, and the off state is never reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.wakeup_request ==
                     (out_res_o.machine_state != evcps_pkg::StWaitPlug)) &&
                    (out_res_o.machine_state != evcps_pkg::StOff))
    else $error("wakeup or state inconsistent");

endmodule

bind ev_charge_pilot_sequencer_core evcps_checker u_evcps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);
